@@ design/assert_macros.svh @@
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("same-cycle property violated");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle property violated");

`else

`define ASSERT_IMPL(name, clk, rst_n, pre, post)
`define ASSERT_NEXT(name, clk, rst_n, pre, post)

`endif

`endif

@@ design/pdrm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and constants of the power domain refcount manager.
package pdrm_pkg;

    localparam int NUM_DOMAINS_DEF = 8;

    localparam int OP_W       = 2;
    localparam int MASK_W     = 9;
    localparam int RCOUNT_W   = 16;
    localparam int FMASK_W    = 8;
    localparam int STATUS_W   = 2;
    localparam int FAILED_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int COUNT_W    = 32;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 16;

    localparam logic [OP_W-1:0] OP_GET   = 2'd0;
    localparam logic [OP_W-1:0] OP_PUT   = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STS_INVALID   = 2'd1;
    localparam logic [STATUS_W-1:0] STS_FAULT     = 2'd2;
    localparam logic [STATUS_W-1:0] STS_UNDERFLOW = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RST_PENDING = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_MASK    = 2'd2;

    localparam logic [FAILED_W-1:0] NO_DOMAIN = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WALK,
        ST_ROLL,
        ST_FINISH
    } t_ctrl_state;

    typedef enum logic [1:0] {
        GADJ_NONE,
        GADJ_INC,
        GADJ_SUB,
        GADJ_DEC
    } t_gadj;

    typedef struct packed {
        logic  load;
        logic  walk;
        logic  roll;
        logic  emit;
        t_gadj gadj;
    } t_dp_cmd;

    typedef struct packed {
        logic do_walk;
        logic is_get;
        logic walk_end;
        logic roll_end;
        logic step_fail;
        logic out_free;
    } t_dp_stat;

endpackage

@@ design/pdrm_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer that steps one request through check, domain walk, rollback and result.
module pdrm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pdrm_pkg::t_dp_stat i_stat,
    output pdrm_pkg::t_dp_cmd  o_cmd
);

    pdrm_pkg::t_ctrl_state r_state;
    pdrm_pkg::t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pdrm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            pdrm_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = pdrm_pkg::ST_CHECK;
                end
            end
            pdrm_pkg::ST_CHECK: begin
                if (i_stat.do_walk) begin
                    o_cmd.gadj = i_stat.is_get ? pdrm_pkg::GADJ_INC : pdrm_pkg::GADJ_SUB;
                    n_state    = pdrm_pkg::ST_WALK;
                end else begin
                    n_state = pdrm_pkg::ST_FINISH;
                end
            end
            pdrm_pkg::ST_WALK: begin
                if (i_stat.walk_end) begin
                    n_state = pdrm_pkg::ST_FINISH;
                end else begin
                    o_cmd.walk = 1'b1;
                    if (i_stat.step_fail) begin
                        n_state = pdrm_pkg::ST_ROLL;
                    end
                end
            end
            pdrm_pkg::ST_ROLL: begin
                if (i_stat.roll_end) begin
                    // A failed get gives back the global reference it took.
                    if (i_stat.is_get) begin
                        o_cmd.gadj = pdrm_pkg::GADJ_DEC;
                    end
                    n_state = pdrm_pkg::ST_FINISH;
                end else begin
                    o_cmd.roll = 1'b1;
                end
            end
            pdrm_pkg::ST_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = pdrm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pdrm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/pdrm_datapath.sv @@
`timescale 1ns / 1ps
// Counts, power bits, global count, per-domain action unit and result register.
module pdrm_datapath #(
    parameter int NUM_DOMAINS = pdrm_pkg::NUM_DOMAINS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pdrm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pdrm_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic [pdrm_pkg::OP_W-1:0]           i_operation,
    input  logic [pdrm_pkg::MASK_W-1:0]         i_domain_mask,
    input  logic [pdrm_pkg::RCOUNT_W-1:0]       i_release_count,
    input  logic [pdrm_pkg::FMASK_W-1:0]        i_resume_fail_mask,
    input  logic [pdrm_pkg::FMASK_W-1:0]        i_suspend_fail_mask,
    input  pdrm_pkg::t_dp_cmd                   i_cmd,
    output pdrm_pkg::t_dp_stat                  o_stat,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [pdrm_pkg::STATUS_W-1:0]       o_status,
    output logic                                o_active,
    output logic [pdrm_pkg::FMASK_W-1:0]        o_powered_mask,
    output logic [pdrm_pkg::FAILED_W-1:0]       o_failed_domain
);

    localparam int CW = $clog2(NUM_DOMAINS + 1);
    localparam int IW = (NUM_DOMAINS > 1) ? $clog2(NUM_DOMAINS) : 1;
    localparam int CNT_W = pdrm_pkg::COUNT_W;
    localparam logic [32:0] ALL_MASK = 33'(1) << NUM_DOMAINS;

    // Configuration.
    logic                              r_cfg_enable;
    logic                              r_cfg_rst_pending;
    logic [pdrm_pkg::FMASK_W-1:0]      r_cfg_reg_mask;

    // Captured request.
    logic [pdrm_pkg::OP_W-1:0]         r_op;
    logic [pdrm_pkg::MASK_W-1:0]       r_mask;
    logic [pdrm_pkg::RCOUNT_W-1:0]     r_cnt;
    logic [pdrm_pkg::FMASK_W-1:0]      r_rfail;
    logic [pdrm_pkg::FMASK_W-1:0]      r_sfail;

    // Domain state.
    logic [CNT_W-1:0]                  r_count [NUM_DOMAINS];
    logic [NUM_DOMAINS-1:0]            r_powered;
    logic [CNT_W-1:0]                  r_global;

    // Walk bookkeeping.
    logic [CW-1:0]                     r_idx;
    logic [pdrm_pkg::FAILED_W-1:0]     r_failed;
    logic                              r_under;

    // Result register.
    logic                              r_out_valid;
    logic [pdrm_pkg::STATUS_W-1:0]     r_out_status;
    logic                              r_out_active;
    logic [pdrm_pkg::FMASK_W-1:0]      r_out_powered;
    logic [pdrm_pkg::FAILED_W-1:0]     r_out_failed;

    logic [NUM_DOMAINS-1:0]            w_sel;
    logic [NUM_DOMAINS-1:0]            w_reg;
    logic [NUM_DOMAINS-1:0]            w_rf;
    logic [NUM_DOMAINS-1:0]            w_sf;
    logic                              w_is_get;
    logic                              w_do_walk;
    logic [pdrm_pkg::STATUS_W-1:0]     w_pre_status;
    logic [pdrm_pkg::STATUS_W-1:0]     w_final_status;

    logic [CW-1:0]                     w_addr_full;
    logic [IW-1:0]                     w_addr;
    logic                              w_in_range;
    logic [CNT_W-1:0]                  w_cur;
    logic                              w_cur_pow;
    logic                              w_cur_sel;
    logic                              w_cur_reg;
    logic                              w_cur_rf;
    logic                              w_cur_sf;
    logic                              w_up;
    logic [CNT_W-1:0]                  w_amt;
    logic [CNT_W:0]                    w_sum;
    logic [CNT_W-1:0]                  w_sat;
    logic [CNT_W-1:0]                  w_diff;
    logic                              w_short;
    logic [CNT_W-1:0]                  w_new_count;
    logic                              w_new_pow;
    logic                              w_fail;
    logic                              w_under;
    logic                              w_apply;

    logic [CNT_W:0]                    w_delta;
    logic [CNT_W:0]                    w_gsum;
    logic [CNT_W-1:0]                  w_gnext;
    logic [31:0]                       w_powered32;

    // Per-domain mask views; the fail and register masks reach domains 0-7 only.
    always_comb begin
        logic        mask_all;
        logic [31:0] mask32;
        logic [31:0] reg32;
        logic [31:0] rf32;
        logic [31:0] sf32;
        mask_all = ({24'b0, r_mask} == ALL_MASK);
        mask32   = {23'b0, r_mask};
        reg32    = {24'b0, r_cfg_reg_mask};
        rf32     = {24'b0, r_rfail};
        sf32     = {24'b0, r_sfail};
        for (int i = 0; i < NUM_DOMAINS; i++) begin
            w_sel[i] = mask_all | mask32[i];
            w_reg[i] = reg32[i];
            w_rf[i]  = rf32[i];
            w_sf[i]  = sf32[i];
        end
    end

    assign w_is_get = (r_op == pdrm_pkg::OP_GET);

    // Request classification; for get and put, the enable check wins over the rest.
    always_comb begin
        w_pre_status = pdrm_pkg::STS_OK;
        w_do_walk    = 1'b0;
        case (r_op)
            pdrm_pkg::OP_GET, pdrm_pkg::OP_PUT: begin
                if (r_cfg_enable) begin
                    if ({24'b0, r_mask} > ALL_MASK) begin
                        w_pre_status = pdrm_pkg::STS_INVALID;
                    end else if (r_mask == '0) begin
                        w_pre_status = pdrm_pkg::STS_OK;
                    end else if (r_cfg_rst_pending) begin
                        w_pre_status = pdrm_pkg::STS_INVALID;
                    end else if (w_is_get || (r_cnt != '0)) begin
                        w_do_walk = 1'b1;
                    end
                end
            end
            pdrm_pkg::OP_QUERY: begin
                w_pre_status = pdrm_pkg::STS_OK;
            end
            default: begin
                w_pre_status = pdrm_pkg::STS_INVALID;
            end
        endcase
    end

    // Rollback works on the domain just below the index, in the opposite direction.
    assign w_addr_full = i_cmd.roll ? (r_idx - 1'b1) : r_idx;
    assign w_addr      = w_addr_full[IW-1:0];
    assign w_in_range  = (w_addr_full < CW'(NUM_DOMAINS));
    assign w_cur       = w_in_range ? r_count[w_addr] : '0;
    assign w_cur_pow   = w_in_range & r_powered[w_addr];
    assign w_cur_sel   = w_in_range & w_sel[w_addr];
    assign w_cur_reg   = w_in_range & w_reg[w_addr];
    assign w_cur_rf    = w_in_range & w_rf[w_addr];
    assign w_cur_sf    = w_in_range & w_sf[w_addr];
    assign w_up        = w_is_get ^ i_cmd.roll;
    assign w_amt       = w_is_get ? CNT_W'(1) : CNT_W'(r_cnt);
    assign w_sum       = {1'b0, w_cur} + {1'b0, w_amt};
    assign w_sat       = w_sum[CNT_W] ? '1 : w_sum[CNT_W-1:0];
    assign w_diff      = w_cur - w_amt;
    assign w_short     = (w_amt > w_cur);

    always_comb begin
        w_new_count = w_cur;
        w_new_pow   = w_cur_pow;
        w_fail      = 1'b0;
        w_under     = 1'b0;
        if (w_up) begin
            if (w_cur_pow) begin
                w_new_count = w_sat;
            end else if (w_cur_reg && w_cur_rf) begin
                // Failed power-up leaves the count as it was.
                w_fail = 1'b1;
            end else begin
                w_new_count = w_sat;
                w_new_pow   = 1'b1;
            end
        end else begin
            if (w_short) begin
                // Underflow clamps to zero and keeps the power state.
                w_new_count = '0;
                w_under     = 1'b1;
            end else begin
                w_new_count = w_diff;
                if ((w_diff == '0) && w_cur_pow) begin
                    if (w_cur_reg && w_cur_sf) begin
                        w_fail = 1'b1;
                    end else begin
                        w_new_pow = 1'b0;
                    end
                end
            end
        end
    end

    assign w_apply = w_cur_sel & (i_cmd.walk | i_cmd.roll);

    // Saturating global count update.
    always_comb begin
        case (i_cmd.gadj)
            pdrm_pkg::GADJ_INC: w_delta = (CNT_W + 1)'(1);
            pdrm_pkg::GADJ_DEC: w_delta = '1;
            pdrm_pkg::GADJ_SUB: w_delta = -(CNT_W + 1)'(r_cnt);
            default:            w_delta = '0;
        endcase
        w_gsum = {r_global[CNT_W-1], r_global} + w_delta;
        if (w_gsum[CNT_W] != w_gsum[CNT_W-1]) begin
            w_gnext = w_gsum[CNT_W] ? {1'b1, {(CNT_W - 1){1'b0}}}
                                    : {1'b0, {(CNT_W - 1){1'b1}}};
        end else begin
            w_gnext = w_gsum[CNT_W-1:0];
        end
    end

    always_comb begin
        if (!w_do_walk) begin
            w_final_status = w_pre_status;
        end else if (r_failed != pdrm_pkg::NO_DOMAIN) begin
            w_final_status = pdrm_pkg::STS_FAULT;
        end else if (r_under) begin
            w_final_status = pdrm_pkg::STS_UNDERFLOW;
        end else begin
            w_final_status = pdrm_pkg::STS_OK;
        end
    end

    assign w_powered32 = 32'(r_powered);

    // Request capture; payload only.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_operation;
            r_mask  <= i_domain_mask;
            r_cnt   <= i_release_count;
            r_rfail <= i_resume_fail_mask;
            r_sfail <= i_suspend_fail_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status  <= w_final_status;
            r_out_active  <= ~r_global[CNT_W-1] & (r_global != '0);
            r_out_powered <= w_powered32[pdrm_pkg::FMASK_W-1:0];
            r_out_failed  <= r_failed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_enable      <= 1'b1;
            r_cfg_rst_pending <= 1'b0;
            r_cfg_reg_mask    <= '0;
            for (int i = 0; i < NUM_DOMAINS; i++) begin
                r_count[i] <= CNT_W'(1);
            end
            r_powered   <= '1;
            r_global    <= CNT_W'(1);
            r_idx       <= '0;
            r_failed    <= pdrm_pkg::NO_DOMAIN;
            r_under     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    pdrm_pkg::CFG_ENABLE:      r_cfg_enable      <= i_cfg_wdata[0];
                    pdrm_pkg::CFG_RST_PENDING: r_cfg_rst_pending <= i_cfg_wdata[0];
                    pdrm_pkg::CFG_REG_MASK:    r_cfg_reg_mask    <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_idx    <= '0;
                r_failed <= pdrm_pkg::NO_DOMAIN;
                r_under  <= 1'b0;
            end
            if (w_apply) begin
                r_count[w_addr]   <= w_new_count;
                r_powered[w_addr] <= w_new_pow;
                if (w_under) begin
                    r_under <= 1'b1;
                end
            end
            if (i_cmd.walk) begin
                // On a fault the index stays on the failing domain for the rollback.
                if (w_cur_sel && w_fail) begin
                    r_failed <= pdrm_pkg::FAILED_W'(r_idx);
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (i_cmd.roll) begin
                r_idx <= r_idx - 1'b1;
            end
            if (i_cmd.gadj != pdrm_pkg::GADJ_NONE) begin
                r_global <= w_gnext;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.do_walk   = w_do_walk;
    assign o_stat.is_get    = w_is_get;
    assign o_stat.walk_end  = (r_idx == CW'(NUM_DOMAINS));
    assign o_stat.roll_end  = (r_idx == '0);
    assign o_stat.step_fail = w_cur_sel & w_fail;
    assign o_stat.out_free  = ~r_out_valid | i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_active        = r_out_active;
    assign o_powered_mask  = r_out_powered;
    assign o_failed_domain = r_out_failed;

endmodule

@@ design/power_domain_refcount_manager.sv @@
`timescale 1ns / 1ps
// Top level of the power domain refcount manager.
//
//  Channel   Direction  Carries
//  s_axis    in         tuser[1:0] operation; tdata domain mask, release count, fail masks
//  m_axis    out        tuser[1:0] status; tdata active, powered mask, failed domain
//  cfg       in         write enable, register index, 8-bit write data
//
// One request is in flight at a time. Query, invalid and no-op requests go from the check
// straight to the result; a walk request steps through every domain, and a fault adds a
// rollback. The walk visits one domain per cycle through a single action unit.
// A finished result waits in the output register while the next request is accepted.
// Reset is synchronous: all counts and the global count go to one, all domains powered.
`include "assert_macros.svh"

module power_domain_refcount_manager #(
    parameter int NUM_DOMAINS = pdrm_pkg::NUM_DOMAINS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pdrm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pdrm_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [8:0] domain_mask, [24:9] release_count, [32:25] resume_fail_mask,
    // [40:33] suspend_fail_mask, [47:41] zero
    input  logic [pdrm_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    // [1:0] operation
    input  logic [pdrm_pkg::OP_W-1:0]          i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [0] active, [8:1] powered_mask, [12:9] failed_domain, [15:13] zero
    output logic [pdrm_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,
    // [1:0] status
    output logic [pdrm_pkg::STATUS_W-1:0]      o_m_axis_tuser
);

    pdrm_pkg::t_dp_cmd                 w_cmd;
    pdrm_pkg::t_dp_stat                w_stat;
    logic                              w_active;
    logic [pdrm_pkg::FMASK_W-1:0]      w_powered;
    logic [pdrm_pkg::FAILED_W-1:0]     w_failed;

    pdrm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    pdrm_datapath #(
        .NUM_DOMAINS (NUM_DOMAINS)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_operation         (i_s_axis_tuser),
        .i_domain_mask       (i_s_axis_tdata[8:0]),
        .i_release_count     (i_s_axis_tdata[24:9]),
        .i_resume_fail_mask  (i_s_axis_tdata[32:25]),
        .i_suspend_fail_mask (i_s_axis_tdata[40:33]),
        .i_cmd               (w_cmd),
        .o_stat              (w_stat),
        .i_out_ready         (i_m_axis_tready),
        .o_out_valid         (o_m_axis_tvalid),
        .o_status            (o_m_axis_tuser),
        .o_active            (w_active),
        .o_powered_mask      (w_powered),
        .o_failed_domain     (w_failed)
    );

    assign o_m_axis_tdata = {3'b000, w_failed, w_powered, w_active};

    // An accepted beat keeps the input closed until its result is written into the output register.
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
                 i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)
    // A result is only written into a free output register.
    `ASSERT_IMPL(a_emit_into_free_slot, i_clk, i_rst_n, w_cmd.emit, w_stat.out_free)
    // The sequencer issues at most one of load, walk, rollback and emit per cycle.
    `ASSERT_IMPL(a_single_step, i_clk, i_rst_n, 1'b1,
                 $onehot0({w_cmd.load, w_cmd.walk, w_cmd.roll, w_cmd.emit}))
    // A reported failing domain is one of the first eight, or none.
    `ASSERT_IMPL(a_failed_in_range, i_clk, i_rst_n, o_m_axis_tvalid,
                 w_failed <= pdrm_pkg::NO_DOMAIN)

endmodule
